FILE: rtl/gwt_pkg.sv
`timescale 1ns / 1ps

package gwt_pkg;

  // field widths of the item and result words
  localparam int CountW = 7;
  localparam int IndexW = 6;
  localparam int CoordW = 16;
  localparam int RegW   = 14;
  localparam int GapW   = 10;
  localparam int CfgIdxW = 3;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_REGION_X      = 3'd0,
    CFG_REGION_Y      = 3'd1,
    CFG_REGION_WIDTH  = 3'd2,
    CFG_REGION_HEIGHT = 3'd3,
    CFG_GAP_PIXELS    = 3'd4
  } cfg_idx_e;

  // smallest c with c*c >= n, for n up to 127
  function automatic logic [3:0] grid_cols(input logic [CountW-1:0] n);
    logic [3:0] c;
    c = 4'd12;
    for (int k = 11; k >= 1; k--) begin
      if (k * k >= int'(n)) c = 4'(k);
    end
    return c;
  endfunction

  // smallest r with r*c >= n, i.e. ceil(n / c)
  function automatic logic [3:0] grid_rows(input logic [CountW-1:0] n, input logic [3:0] c);
    logic [3:0] r;
    r = 4'd12;
    for (int k = 11; k >= 1; k--) begin
      if (k * int'(c) >= int'(n)) r = 4'(k);
    end
    return r;
  endfunction

  // ceil(2^10 / c): exact floor quotient for a 6-bit index
  function automatic logic [10:0] recip_idx(input logic [3:0] c);
    logic [10:0] m;
    unique case (c)
      4'd2:    m = 11'd512;
      4'd3:    m = 11'd342;
      4'd4:    m = 11'd256;
      4'd5:    m = 11'd205;
      4'd6:    m = 11'd171;
      4'd7:    m = 11'd147;
      4'd8:    m = 11'd128;
      4'd9:    m = 11'd114;
      4'd10:   m = 11'd103;
      4'd11:   m = 11'd94;
      4'd12:   m = 11'd86;
      default: m = 11'd1024;
    endcase
    return m;
  endfunction

  // ceil(2^18 / c): exact floor quotient for a 14-bit magnitude
  function automatic logic [18:0] recip_div(input logic [3:0] c);
    logic [18:0] m;
    unique case (c)
      4'd2:    m = 19'd131072;
      4'd3:    m = 19'd87382;
      4'd4:    m = 19'd65536;
      4'd5:    m = 19'd52429;
      4'd6:    m = 19'd43691;
      4'd7:    m = 19'd37450;
      4'd8:    m = 19'd32768;
      4'd9:    m = 19'd29128;
      4'd10:   m = 19'd26215;
      4'd11:   m = 19'd23832;
      4'd12:   m = 19'd21846;
      default: m = 19'd262144;
    endcase
    return m;
  endfunction

  // clamp to the 16-bit signed range
  function automatic logic [CoordW-1:0] sat16(input logic signed [21:0] v);
    logic [CoordW-1:0] r;
    if (v > 22'sd32767) begin
      r = 16'h7fff;
    end else if (v < -22'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/gwt_in_if.sv
`timescale 1ns / 1ps

interface gwt_in_if
  import gwt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] client_count;
  logic [IndexW-1:0] client_index;
  logic              client_floating;

  modport source (output valid, client_count, client_index, client_floating, input ready);
  modport sink   (input valid, client_count, client_index, client_floating, output ready);
endinterface

FILE: rtl/gwt_out_if.sv
`timescale 1ns / 1ps

interface gwt_out_if
  import gwt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              placed;
  logic [CoordW-1:0] win_x;
  logic [CoordW-1:0] win_y;
  logic [CoordW-1:0] win_width;
  logic [CoordW-1:0] win_height;

  modport source (output valid, placed, win_x, win_y, win_width, win_height, input ready);
  modport sink   (input valid, placed, win_x, win_y, win_width, win_height, output ready);
endinterface

FILE: rtl/grid_window_tiler.sv
`timescale 1ns / 1ps

// channel   dir  word                                      handshake
// in_i      in   client_count, client_index, floating      valid/ready
// out_o     out  placed, win_x, win_y, win_width, height   valid/ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i            write enable, no wait
//
// six register stages, one word per cycle while out_o.ready is high;
// the stages hold the two reciprocal multiplies and the offset multiply per axis
// reset clears the stage valid bits and loads the register reset values
// a stall holds each full stage; empty stages still fill, so ready stays
// high while any stage up to the output has a bubble

module grid_window_tiler
  import gwt_pkg::*;
#(
  parameter int MAX_CLIENTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_data_i,
  gwt_in_if.sink             in_i,
  gwt_out_if.source          out_o
);

  localparam int NStages = 6;

  // configuration registers
  logic [RegW-1:0] rx_q, ry_q, rw_q, rh_q;
  logic [GapW-1:0] gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q  <= '0;
      ry_q  <= '0;
      rw_q  <= 14'd1920;
      rh_q  <= 14'd1080;
      gap_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REGION_X:      rx_q  <= cfg_data_i;
        CFG_REGION_Y:      ry_q  <= cfg_data_i;
        CFG_REGION_WIDTH:  rw_q  <= cfg_data_i;
        CFG_REGION_HEIGHT: rh_q  <= cfg_data_i;
        CFG_GAP_PIXELS:    gap_q <= cfg_data_i[GapW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic [NStages:1]   v_q;
  logic [NStages+1:1] en;

  assign en[NStages+1] = out_o.ready;
  for (genvar k = 1; k <= NStages; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign in_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_i.valid;
      for (int k = 2; k <= NStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: validity check and grid shape
  logic              ok1_q;
  logic [IndexW-1:0] idx1_q;
  logic [3:0]        cols1_q, rows1_q;
  logic              ok1_d;

  assign ok1_d = (in_i.client_count != '0)
              && (int'(in_i.client_count) <= MAX_CLIENTS)
              && ({1'b0, in_i.client_index} < in_i.client_count)
              && !in_i.client_floating;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ok1_q   <= ok1_d;
      idx1_q  <= in_i.client_index;
      cols1_q <= grid_cols(in_i.client_count);
      rows1_q <= grid_rows(in_i.client_count, grid_cols(in_i.client_count));
    end
  end

  // stage 2: numerators after gaps, row of the client
  logic                     ok2_q;
  logic [IndexW-1:0]        idx2_q;
  logic [3:0]               cols2_q, rows2_q;
  logic signed [CoordW-1:0] nw2_q, nh2_q;
  logic [5:0]               row2_q;
  logic [4:0]               cspan, rspan;
  logic [13:0]              gx, gy;
  logic [16:0]              rprod;

  assign cspan = {1'b0, cols1_q} + 5'd1;
  assign rspan = {1'b0, rows1_q} + 5'd1;
  assign gx    = {4'b0, gap_q} * {9'b0, cspan};
  assign gy    = {4'b0, gap_q} * {9'b0, rspan};
  assign rprod = {11'b0, idx1_q} * {6'b0, recip_idx(cols1_q)};

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ok2_q   <= ok1_q;
      idx2_q  <= idx1_q;
      cols2_q <= cols1_q;
      rows2_q <= rows1_q;
      nw2_q   <= $signed({2'b0, rw_q}) - $signed({2'b0, gx});
      nh2_q   <= $signed({2'b0, rh_q}) - $signed({2'b0, gy});
      row2_q  <= rprod[15:10];
    end
  end

  // stage 3: magnitude times reciprocal, column of the client
  logic        ok3_q;
  logic [3:0]  col3_q, row3_q;
  logic        negw3_q, negh3_q;
  logic [32:0] pw3_q, ph3_q;
  logic [15:0] nwn, nhn;
  logic [13:0] magw, magh;
  logic [9:0]  rc;
  logic [5:0]  cd;

  assign nwn  = -nw2_q;
  assign nhn  = -nh2_q;
  assign magw = nw2_q[15] ? nwn[13:0] : nw2_q[13:0];
  assign magh = nh2_q[15] ? nhn[13:0] : nh2_q[13:0];
  assign rc   = {4'b0, row2_q} * {6'b0, cols2_q};
  assign cd   = idx2_q - rc[5:0];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ok3_q   <= ok2_q;
      col3_q  <= cd[3:0];
      row3_q  <= row2_q[3:0];
      negw3_q <= nw2_q[15];
      negh3_q <= nh2_q[15];
      pw3_q   <= {19'b0, magw} * {14'b0, recip_div(cols2_q)};
      ph3_q   <= {19'b0, magh} * {14'b0, recip_div(rows2_q)};
    end
  end

  // stage 4: signed cell size, truncated toward zero
  logic                     ok4_q;
  logic [3:0]               col4_q, row4_q;
  logic signed [CoordW-1:0] cw4_q, ch4_q;
  logic [15:0]              qw, qh;

  assign qw = {1'b0, pw3_q[32:18]};
  assign qh = {1'b0, ph3_q[32:18]};

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      ok4_q  <= ok3_q;
      col4_q <= col3_q;
      row4_q <= row3_q;
      cw4_q  <= negw3_q ? -qw : qw;
      ch4_q  <= negh3_q ? -qh : qh;
    end
  end

  // stage 5: cell offsets from the first cell
  logic                     ok5_q;
  logic signed [CoordW-1:0] cw5_q, ch5_q;
  logic signed [20:0]       px5_q, py5_q;
  logic [16:0]              stepw, steph;

  assign stepw = {cw4_q[15], cw4_q} + {7'b0, gap_q};
  assign steph = {ch4_q[15], ch4_q} + {7'b0, gap_q};

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      ok5_q <= ok4_q;
      cw5_q <= cw4_q;
      ch5_q <= ch4_q;
      px5_q <= $signed({17'b0, col4_q}) * $signed({{4{stepw[16]}}, stepw});
      py5_q <= $signed({17'b0, row4_q}) * $signed({{4{steph[16]}}, steph});
    end
  end

  // stage 6: absolute position, clamp, output register
  logic              placed_q;
  logic [CoordW-1:0] wx_q, wy_q, ww_q, wh_q;
  logic [21:0]       basex, basey;
  logic signed [21:0] posx, posy;

  assign basex = {8'b0, rx_q} + {12'b0, gap_q};
  assign basey = {8'b0, ry_q} + {12'b0, gap_q};
  assign posx  = $signed(basex) + $signed({px5_q[20], px5_q});
  assign posy  = $signed(basey) + $signed({py5_q[20], py5_q});

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      placed_q <= ok5_q;
      wx_q     <= ok5_q ? sat16(posx) : '0;
      wy_q     <= ok5_q ? sat16(posy) : '0;
      ww_q     <= ok5_q ? cw5_q : '0;
      wh_q     <= ok5_q ? ch5_q : '0;
    end
  end

  assign out_o.valid      = v_q[NStages];
  assign out_o.placed     = placed_q;
  assign out_o.win_x      = wx_q;
  assign out_o.win_y      = wy_q;
  assign out_o.win_width  = ww_q;
  assign out_o.win_height = wh_q;

  // a word that is not placed carries zero geometry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.placed |->
      out_o.win_x == '0 && out_o.win_y == '0 && out_o.win_width == '0 && out_o.win_height == '0)
    else $error("unplaced word with nonzero geometry");

  // an empty output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output stage");

  // ready only when some stage can take a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !(&v_q) || out_o.ready)
    else $error("input ready while the pipeline is full and stalled");

endmodule
